// File: design/mnfc_pkg.sv
// shared types, constants and code functions for the manchester nibble frame codec
package mnfc_pkg;

  localparam int MAX_LINE_BYTES = 64;
  localparam int LIMIT_CAP      = (MAX_LINE_BYTES - 2) / 2;
  localparam int LIMIT_W        = 5;
  localparam int CNT_W          = 6;
  localparam logic [LIMIT_W-1:0] LIMIT_CAP_V =
    LIMIT_W'((LIMIT_CAP > 31) ? 31 : LIMIT_CAP);
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd31;

  localparam int OPQ_DEPTH = 4;
  localparam int OPQ_PTR_W = $clog2(OPQ_DEPTH);
  localparam int OPQ_CNT_W = $clog2(OPQ_DEPTH + 1);

  localparam logic [7:0] HDR_BYTE  = 8'h55 & 8'hfc;
  localparam logic [7:0] TERM_BYTE = 8'h00;

  localparam logic CMD_ENC = 1'b0;
  localparam logic CMD_DEC = 1'b1;

  localparam int FLAG_FRAMING = 0;
  localparam int FLAG_SIZE    = 1;
  localparam int FLAG_CODE    = 2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_PROTO = 2'd1;
  localparam logic [1:0] ST_LONG  = 2'd2;

  // result slots of one item, issued lowest first
  localparam int RES_HDR  = 0;
  localparam int RES_LO   = 1;
  localparam int RES_HI   = 2;
  localparam int RES_BYTE = 3;
  localparam int RES_TERM = 4;
  localparam int RES_N    = 5;

  typedef struct packed {
    logic       hdr;
    logic       enc;
    logic       dec;
    logic       term;
    logic       term_pres;
    logic [1:0] status;
    logic [7:0] data;
  } op_t;

  function automatic logic [7:0] nib_code(input logic [3:0] n);
    return {n[3], ~n[3], n[2], ~n[2], n[1], ~n[1], n[0], ~n[0]};
  endfunction

  // {valid, nibble}
  function automatic logic [4:0] code_to_nib(input logic [7:0] b);
    logic ok;
    ok = (b[7] ^ b[6]) & (b[5] ^ b[4]) & (b[3] ^ b[2]) & (b[1] ^ b[0]);
    return {ok, b[7], b[5], b[3], b[1]};
  endfunction

  function automatic logic [1:0] status_of(input logic [2:0] flags);
    logic [1:0] st;
    if (flags[FLAG_FRAMING]) st = ST_PROTO;
    else if (flags[FLAG_SIZE]) st = ST_LONG;
    else if (flags[FLAG_CODE]) st = ST_PROTO;
    else st = ST_OK;
    return st;
  endfunction

endpackage

// File: design/manchester_nibble_frame_codec_top.sv
// top level of the manchester nibble frame codec
// The front end takes one item per cycle whenever the four-entry op queue has room,
// and the back end drains one result item per cycle from that queue into the output
// register whenever that register is empty or popped. An encode item gives two line
// bytes while the frame is under its size limit, plus one for the frame header when
// it opens a frame and one for the terminator when it ends one; a decode item gives at
// most one result, so decode runs at one item per cycle while the output is popped.
module manchester_nibble_frame_codec_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [4:0] cfg_wdata_i,
  input  logic       push,
  output logic       full,
  input  logic       cmd_i,
  input  logic [7:0] data_byte_i,
  input  logic       frame_end_i,
  input  logic       pop,
  output logic       empty,
  output logic [7:0] out_byte_o,
  output logic       byte_present_o,
  output logic       run_last_o,
  output logic [1:0] frame_status_o
);

  logic          accept;
  logic          op_valid;
  mnfc_pkg::op_t op_in, op_out;
  logic          q_avail, q_rd;

  assign accept = push && !full;

  mnfc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .cmd_i       (cmd_i),
    .data_byte_i (data_byte_i),
    .frame_end_i (frame_end_i),
    .op_valid_o  (op_valid),
    .op_o        (op_in)
  );

  mnfc_opq u_opq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (op_valid),
    .wr_op_i (op_in),
    .full_o  (full),
    .rd_i    (q_rd),
    .avail_o (q_avail),
    .rd_op_o (op_out)
  );

  mnfc_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .avail_i        (q_avail),
    .op_i           (op_out),
    .rd_o           (q_rd),
    .pop_i          (pop),
    .empty_o        (empty),
    .out_byte_o     (out_byte_o),
    .byte_present_o (byte_present_o),
    .run_last_o     (run_last_o),
    .frame_status_o (frame_status_o)
  );

endmodule

// File: design/mnfc_front.sv
// front end: takes items, tracks frame state and issues at most one op per item
module mnfc_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [mnfc_pkg::LIMIT_W-1:0]   cfg_wdata_i,
  input  logic                           accept_i,
  input  logic                           cmd_i,
  input  logic [7:0]                     data_byte_i,
  input  logic                           frame_end_i,
  output logic                           op_valid_o,
  output mnfc_pkg::op_t                  op_o
);

  logic [mnfc_pkg::LIMIT_W-1:0] limit_q;
  logic                         inside_q, inside_d;
  logic [mnfc_pkg::CNT_W-1:0]   cnt_q, cnt_d;
  logic                         hp_q, hp_d;
  logic [3:0]                   held_q, held_d;
  logic [2:0]                   flags_q, flags_d;

  logic [mnfc_pkg::LIMIT_W-1:0] limit_now;
  logic                         room;
  logic [4:0]                   dec_nib;
  mnfc_pkg::op_t                op;

  assign limit_now = (limit_q < mnfc_pkg::LIMIT_CAP_V) ? limit_q : mnfc_pkg::LIMIT_CAP_V;
  assign room      = cnt_q < {1'b0, limit_now};
  assign dec_nib   = mnfc_pkg::code_to_nib(data_byte_i);

  always_comb begin
    inside_d     = 1'b1;
    cnt_d        = cnt_q;
    hp_d         = hp_q;
    held_d       = held_q;
    flags_d      = flags_q;
    op           = '0;
    op.term_pres = 1'b1;
    if (cmd_i == mnfc_pkg::CMD_ENC) begin
      op.hdr  = !inside_q;
      op.data = data_byte_i;
      if (room) begin
        cnt_d  = cnt_q + 1'b1;
        op.enc = 1'b1;
      end else begin
        flags_d[mnfc_pkg::FLAG_SIZE] = 1'b1;
      end
      op.term = frame_end_i;
    end else if (!inside_q) begin
      if (frame_end_i) begin
        flags_d[mnfc_pkg::FLAG_FRAMING] = 1'b1;
        op.term      = 1'b1;
        op.term_pres = 1'b0;
      end
    end else if (frame_end_i) begin
      if (data_byte_i != mnfc_pkg::TERM_BYTE || hp_q) flags_d[mnfc_pkg::FLAG_FRAMING] = 1'b1;
      op.term      = 1'b1;
      op.term_pres = 1'b0;
    end else if (!hp_q) begin
      if (!dec_nib[4]) flags_d[mnfc_pkg::FLAG_CODE] = 1'b1;
      held_d = dec_nib[4] ? dec_nib[3:0] : 4'h0;
      hp_d   = 1'b1;
    end else begin
      hp_d   = 1'b0;
      held_d = 4'h0;
      op.data = {dec_nib[3:0], held_q};
      if (room) begin
        cnt_d = cnt_q + 1'b1;
        if (!dec_nib[4]) flags_d[mnfc_pkg::FLAG_CODE] = 1'b1;
        else if (!flags_q[mnfc_pkg::FLAG_CODE]) op.dec = 1'b1;
      end else begin
        flags_d[mnfc_pkg::FLAG_SIZE] = 1'b1;
      end
    end
    op.status = mnfc_pkg::status_of(flags_d);
    if (op.term) begin
      inside_d = 1'b0;
      cnt_d    = '0;
      hp_d     = 1'b0;
      held_d   = 4'h0;
      flags_d  = '0;
    end
  end

  assign op_o       = op;
  assign op_valid_o = accept_i && (op.hdr || op.enc || op.dec || op.term);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q  <= mnfc_pkg::LIMIT_RESET;
      inside_q <= 1'b0;
      cnt_q    <= '0;
      hp_q     <= 1'b0;
      held_q   <= 4'h0;
      flags_q  <= '0;
    end else begin
      if (cfg_we_i) limit_q <= cfg_wdata_i;
      if (accept_i) begin
        inside_q <= inside_d;
        cnt_q    <= cnt_d;
        hp_q     <= hp_d;
        held_q   <= held_d;
        flags_q  <= flags_d;
      end
    end
  end

endmodule

// File: design/mnfc_opq.sv
// short op queue between front and back end
module mnfc_opq (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_i,
  input  mnfc_pkg::op_t wr_op_i,
  output logic          full_o,
  input  logic          rd_i,
  output logic          avail_o,
  output mnfc_pkg::op_t rd_op_o
);

  mnfc_pkg::op_t                  mem_q [mnfc_pkg::OPQ_DEPTH];
  logic [mnfc_pkg::OPQ_PTR_W-1:0] wptr_q, rptr_q;
  logic [mnfc_pkg::OPQ_CNT_W-1:0] cnt_q;

  assign full_o  = cnt_q == mnfc_pkg::OPQ_CNT_W'(mnfc_pkg::OPQ_DEPTH);
  assign avail_o = cnt_q != '0;
  assign rd_op_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (wr_i) mem_q[wptr_q] <= wr_op_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (wr_i) wptr_q <= wptr_q + 1'b1;
      if (rd_i) rptr_q <= rptr_q + 1'b1;
      if (wr_i && !rd_i) cnt_q <= cnt_q + 1'b1;
      else if (rd_i && !wr_i) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

// File: design/mnfc_back.sv
// back end: expands each op into result items, one per cycle while the output register is free or popped
module mnfc_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          avail_i,
  input  mnfc_pkg::op_t op_i,
  output logic          rd_o,
  input  logic          pop_i,
  output logic          empty_o,
  output logic [7:0]    out_byte_o,
  output logic          byte_present_o,
  output logic          run_last_o,
  output logic [1:0]    frame_status_o
);

  logic [mnfc_pkg::RES_N-1:0] done_q, done_d;
  logic [mnfc_pkg::RES_N-1:0] mask, rest, pick;
  logic                       out_valid_q;
  logic [7:0]                 byte_q, byte_d;
  logic                       pres_q, pres_d;
  logic                       last_q, last_d;
  logic [1:0]                 stat_q, stat_d;
  logic                       load;

  always_comb begin
    mask = '0;
    mask[mnfc_pkg::RES_HDR]  = op_i.hdr;
    mask[mnfc_pkg::RES_LO]   = op_i.enc;
    mask[mnfc_pkg::RES_HI]   = op_i.enc;
    mask[mnfc_pkg::RES_BYTE] = op_i.dec;
    mask[mnfc_pkg::RES_TERM] = op_i.term;
  end

  assign rest = mask & ~done_q;
  assign pick = rest & (~rest + 1'b1);
  assign load = avail_i && (!out_valid_q || pop_i);
  assign rd_o = load && (rest == pick);

  always_comb begin
    byte_d = op_i.data;
    pres_d = 1'b1;
    last_d = 1'b0;
    stat_d = mnfc_pkg::ST_OK;
    unique case (1'b1)
      pick[mnfc_pkg::RES_HDR]:  byte_d = mnfc_pkg::HDR_BYTE;
      pick[mnfc_pkg::RES_LO]:   byte_d = mnfc_pkg::nib_code(op_i.data[3:0]);
      pick[mnfc_pkg::RES_HI]:   byte_d = mnfc_pkg::nib_code(op_i.data[7:4]);
      pick[mnfc_pkg::RES_BYTE]: byte_d = op_i.data;
      pick[mnfc_pkg::RES_TERM]: begin
        byte_d = mnfc_pkg::TERM_BYTE;
        pres_d = op_i.term_pres;
        last_d = 1'b1;
        stat_d = op_i.status;
      end
      default: byte_d = op_i.data;
    endcase
    done_d = done_q;
    if (load) done_d = rd_o ? '0 : (done_q | pick);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      done_q <= done_d;
      if (load) out_valid_q <= 1'b1;
      else if (pop_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= byte_d;
      pres_q <= pres_d;
      last_q <= last_d;
      stat_q <= stat_d;
    end
  end

  assign empty_o        = !out_valid_q;
  assign out_byte_o     = byte_q;
  assign byte_present_o = pres_q;
  assign run_last_o     = last_q;
  assign frame_status_o = stat_q;

endmodule

// File: design/mnfc_checker.sv
// port-level checks for the codec and their binding to the top level
module mnfc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       pop,
  input logic       empty,
  input logic [7:0] out_byte_o,
  input logic       byte_present_o,
  input logic       run_last_o,
  input logic [1:0] frame_status_o
);

  a_status_only_is_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !byte_present_o) |-> run_last_o)
    else $error("status-only item not final");

  a_status_only_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !byte_present_o) |-> (out_byte_o == mnfc_pkg::TERM_BYTE))
    else $error("status-only item carries a byte");

  a_status_on_final_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !run_last_o) |-> (frame_status_o == mnfc_pkg::ST_OK))
    else $error("status on non-final item");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (frame_status_o <= mnfc_pkg::ST_LONG))
    else $error("undefined status code");

  a_held_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_byte_o) && $stable(run_last_o)))
    else $error("waiting item changed");

endmodule

bind manchester_nibble_frame_codec_top mnfc_checker u_mnfc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .pop            (pop),
  .empty          (empty),
  .out_byte_o     (out_byte_o),
  .byte_present_o (byte_present_o),
  .run_last_o     (run_last_o),
  .frame_status_o (frame_status_o)
);
